@@ rtl/core/ascp_pkg.sv @@
package ascp_pkg;

    localparam logic [3:0] LineLastPos  = 4'd13;
    localparam logic [3:0] IdLastPos    = 4'd2;
    localparam logic [3:0] RtrPos       = 4'd3;
    localparam logic [3:0] DlcPos       = 4'd4;
    localparam logic [3:0] FirstDataPos = 4'd5;
    localparam logic [3:0] MaxLen       = 4'd8;
    localparam int         NumBytes     = 8;

    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharOne   = 8'h31;
    localparam logic [7:0] CharNine  = 8'h39;
    localparam logic [7:0] CharUpA   = 8'h41;
    localparam logic [7:0] CharUpF   = 8'h46;
    localparam logic [7:0] HexLetterBase = 8'd10;
    localparam logic [11:0] NullId   = 12'h000;

    typedef struct packed {
        logic [11:0]                 frame_id;
        logic                        remote_request;
        logic [3:0]                  data_length;
        logic [NumBytes-1:0][7:0]    payload;
        logic                        format_error;
    } t_frame;

endpackage

@@ rtl/core/ascp_parse.sv @@
module ascp_parse (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [7:0]     i_byte,
    input  logic           i_start,
    output logic           o_complete,
    output ascp_pkg::t_frame o_frame
);
    import ascp_pkg::*;

    logic [3:0]               r_pos, n_pos;
    logic [11:0]              r_id, n_id;
    logic                     r_rtr, n_rtr;
    logic [3:0]               r_len, n_len;
    logic [NumBytes-1:0][7:0] r_payload, n_payload;
    logic                     r_err, n_err;
    logic [3:0]               pos;
    logic [7:0]               dlc;
    logic [2:0]               slot;

    always_comb begin
        pos = i_start ? 4'd0 : r_pos;
        if (pos > LineLastPos) begin
            pos = 4'd0;
        end
        n_id      = r_id;
        n_rtr     = r_rtr;
        n_len     = r_len;
        n_payload = r_payload;
        n_err     = r_err;
        if (pos == 4'd0) begin
            n_id      = NullId;
            n_rtr     = 1'b0;
            n_len     = 4'd0;
            n_payload = '0;
            n_err     = 1'b0;
        end
        dlc  = i_byte - CharZero;
        slot = 3'(pos - FirstDataPos);
        if (pos <= IdLastPos) begin
            if (i_byte >= CharZero && i_byte <= CharNine) begin
                n_id = {n_id[7:0], dlc[3:0]};
            end else if (i_byte >= CharUpA && i_byte <= CharUpF) begin
                n_id = {n_id[7:0], 4'(i_byte - CharUpA + HexLetterBase)};
            end
        end else if (pos == RtrPos) begin
            n_rtr = (i_byte == CharOne);
            if (i_byte != CharZero && i_byte != CharOne) begin
                n_err = 1'b1;
            end
        end else if (pos == DlcPos) begin
            if (dlc > 8'(MaxLen)) begin
                n_len = MaxLen;
                n_err = 1'b1;
            end else begin
                n_len = dlc[3:0];
            end
        end else if (pos < LineLastPos) begin
            n_payload[slot] = i_byte;
        end
        n_pos = (pos >= LineLastPos) ? 4'd0 : pos + 4'd1;
    end

    assign o_complete              = (pos == LineLastPos);
    assign o_frame.frame_id        = r_id;
    assign o_frame.remote_request  = r_rtr;
    assign o_frame.data_length     = r_len;
    assign o_frame.payload         = r_payload;
    assign o_frame.format_error    = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 4'd0;
            r_id      <= NullId;
            r_rtr     <= 1'b0;
            r_len     <= 4'd0;
            r_payload <= '0;
            r_err     <= 1'b0;
        end else if (i_en) begin
            r_pos     <= n_pos;
            r_id      <= n_id;
            r_rtr     <= n_rtr;
            r_len     <= n_len;
            r_payload <= n_payload;
            r_err     <= n_err;
        end
    end

endmodule

@@ rtl/core/ascp_dedup.sv @@
module ascp_dedup (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_complete,
    input  ascp_pkg::t_frame i_frame,
    output logic             o_emit,
    output ascp_pkg::t_frame o_frame
);
    import ascp_pkg::*;

    t_frame r_prev;
    logic   same;

    always_comb begin
        same = (r_prev.frame_id == i_frame.frame_id)
            && (r_prev.remote_request == i_frame.remote_request)
            && (r_prev.data_length == i_frame.data_length);
        o_frame = i_frame;
        for (int k = 0; k < NumBytes; k++) begin
            if (4'(k) >= i_frame.data_length) begin
                o_frame.payload[k] = 8'd0;
            end else if (r_prev.payload[k] != i_frame.payload[k]) begin
                same = 1'b0;
            end
        end
    end

    assign o_emit = i_complete && (i_frame.frame_id != NullId) && !same;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_en && o_emit) begin
            r_prev <= i_frame;
        end
    end

endmodule

@@ rtl/core/ascii_can_frame_parser_dedup_top.sv @@
// Parser for fourteen-character text lines that describe CAN frames, with
// suppression of repeated frames.
// The input channel (i_valid, o_stall) carries one character per transaction
// in i_rx_byte; i_line_start marks the first character of a line and drops
// any partial line. The output channel (o_valid, i_stall) carries one decoded
// frame per transaction, produced by the terminator character when the
// identifier is nonzero and the frame differs from the last one sent.
// Throughput is one character per cycle while no frame waits under i_stall.
// A character passes an input register and the parse logic, and its frame is
// loaded into the output register when the terminator leaves the input register.
// Reset clears the line position, the frame being built and the record of
// the last frame sent, and empties both pipeline registers.
// While a frame waits under i_stall, the character already held in the input
// register is kept and o_stall is raised; characters are taken again in the
// cycle in which the waiting frame is taken.
module ascii_can_frame_parser_dedup_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_line_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_frame_id,
    output logic        o_remote_request,
    output logic [3:0]  o_data_length,
    output logic [7:0]  o_data_byte0,
    output logic [7:0]  o_data_byte1,
    output logic [7:0]  o_data_byte2,
    output logic [7:0]  o_data_byte3,
    output logic [7:0]  o_data_byte4,
    output logic [7:0]  o_data_byte5,
    output logic [7:0]  o_data_byte6,
    output logic [7:0]  o_data_byte7,
    output logic        o_format_error
);
    import ascp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_start;
    logic       r_out_valid;
    t_frame     r_out;
    logic       out_blocked;
    logic       proc;
    logic       complete;
    logic       emit;
    t_frame     cur_frame;
    t_frame     emit_frame;

    assign out_blocked = r_out_valid && i_stall;
    assign o_stall     = r_in_valid && out_blocked;
    assign proc        = r_in_valid && !out_blocked;

    ascp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (proc),
        .i_byte     (r_byte),
        .i_start    (r_start),
        .o_complete (complete),
        .o_frame    (cur_frame)
    );

    ascp_dedup u_dedup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (proc),
        .i_complete (complete),
        .i_frame    (cur_frame),
        .o_emit     (emit),
        .o_frame    (emit_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (proc && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte  <= i_rx_byte;
            r_start <= i_line_start;
        end
        if (proc && emit) begin
            r_out <= emit_frame;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_frame_id       = r_out.frame_id;
    assign o_remote_request = r_out.remote_request;
    assign o_data_length    = r_out.data_length;
    assign o_data_byte0     = r_out.payload[0];
    assign o_data_byte1     = r_out.payload[1];
    assign o_data_byte2     = r_out.payload[2];
    assign o_data_byte3     = r_out.payload[3];
    assign o_data_byte4     = r_out.payload[4];
    assign o_data_byte5     = r_out.payload[5];
    assign o_data_byte6     = r_out.payload[6];
    assign o_data_byte7     = r_out.payload[7];
    assign o_format_error   = r_out.format_error;

    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_frame_id != NullId)
        else $error("frame with null identifier sent");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data_length <= MaxLen)
        else $error("data length above eight");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting frame");

    a_tail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data_length < MaxLen |-> o_data_byte7 == 8'd0)
        else $error("byte beyond data length not zero");

endmodule

@@ dv/can_frame_checker.sv @@
module can_frame_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_char_valid,
    input  logic             i_char_stall,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_line_start,
    input  logic             i_frame_valid,
    input  logic             i_frame_stall,
    input  ascp_pkg::t_frame i_frame,
    output int               o_mismatches,
    output int               o_pending
);
    import ascp_pkg::*;

    logic [3:0]  line_pos;
    logic [11:0] id_acc;
    logic        cur_rtr;
    logic [3:0]  cur_len;
    logic [7:0]  cur_bytes [NumBytes];
    logic        cur_err;
    logic [11:0] last_id;
    logic        last_rtr;
    logic [3:0]  last_len;
    logic [7:0]  last_bytes [NumBytes];

    t_frame expected_frames [$];
    t_frame want;

    // Advances the line decoder by one character and queues the frame that a
    // completed, new, nonzero-identifier line produces.
    task automatic parse_char(input logic [7:0] c, input logic start);
        logic [3:0] pos;
        logic [7:0] dlc;
        logic       same_frame;
        t_frame     f;
        pos = start ? 4'd0 : line_pos;
        if (pos > LineLastPos) begin
            pos = 4'd0;
        end
        if (pos == 4'd0) begin
            id_acc  = NullId;
            cur_rtr = 1'b0;
            cur_len = 4'd0;
            cur_err = 1'b0;
            for (int k = 0; k < NumBytes; k++) begin
                cur_bytes[k] = 8'h00;
            end
        end
        if (pos <= IdLastPos) begin
            if (c >= CharZero && c <= CharNine) begin
                id_acc = {id_acc[7:0], 4'(c - CharZero)};
            end else if (c >= CharUpA && c <= CharUpF) begin
                id_acc = {id_acc[7:0], 4'(c - CharUpA + HexLetterBase)};
            end
        end else if (pos == RtrPos) begin
            if (c == CharZero) begin
                cur_rtr = 1'b0;
            end else if (c == CharOne) begin
                cur_rtr = 1'b1;
            end else begin
                cur_rtr = 1'b0;
                cur_err = 1'b1;
            end
        end else if (pos == DlcPos) begin
            dlc = c - CharZero;
            if (dlc > 8'(MaxLen)) begin
                dlc     = 8'(MaxLen);
                cur_err = 1'b1;
            end
            cur_len = dlc[3:0];
        end else if (pos < LineLastPos) begin
            cur_bytes[3'(pos - FirstDataPos)] = c;
        end else begin
            same_frame = (id_acc == last_id) && (cur_rtr == last_rtr) && (cur_len == last_len);
            for (int k = 0; k < NumBytes; k++) begin
                if (k < cur_len && last_bytes[k] != cur_bytes[k]) begin
                    same_frame = 1'b0;
                end
            end
            if (id_acc != NullId && !same_frame) begin
                f.frame_id       = id_acc;
                f.remote_request = cur_rtr;
                f.data_length    = cur_len;
                f.format_error   = cur_err;
                for (int k = 0; k < NumBytes; k++) begin
                    f.payload[k] = (k < cur_len) ? cur_bytes[k] : 8'h00;
                end
                expected_frames.push_back(f);
                last_id    = id_acc;
                last_rtr   = cur_rtr;
                last_len   = cur_len;
                last_bytes = cur_bytes;
            end
        end
        line_pos = (pos >= LineLastPos) ? 4'd0 : pos + 4'd1;
    endtask

    task automatic check_field(input string name, input logic [11:0] exp_val,
                               input logic [11:0] act_val);
        if (exp_val !== act_val) begin
            o_mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_pos     = 4'd0;
            id_acc       = NullId;
            cur_rtr      = 1'b0;
            cur_len      = 4'd0;
            cur_err      = 1'b0;
            last_id      = NullId;
            last_rtr     = 1'b0;
            last_len     = 4'd0;
            o_mismatches = 0;
            for (int k = 0; k < NumBytes; k++) begin
                cur_bytes[k]  = 8'h00;
                last_bytes[k] = 8'h00;
            end
            expected_frames.delete();
        end else begin
            if (i_char_valid && !i_char_stall) begin
                parse_char(i_rx_byte, i_line_start);
            end
            if (i_frame_valid && !i_frame_stall) begin
                if (expected_frames.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: unexpected frame, expected none, actual id 0x%0h",
                             $time, i_frame.frame_id);
                end else begin
                    want = expected_frames.pop_front();
                    check_field("frame_id", want.frame_id, i_frame.frame_id);
                    check_field("remote_request", 12'(want.remote_request),
                                12'(i_frame.remote_request));
                    check_field("data_length", 12'(want.data_length),
                                12'(i_frame.data_length));
                    for (int k = 0; k < NumBytes; k++) begin
                        check_field($sformatf("data_byte%0d", k), 12'(want.payload[k]),
                                    12'(i_frame.payload[k]));
                    end
                    check_field("format_error", 12'(want.format_error),
                                12'(i_frame.format_error));
                end
            end
        end
        o_pending = expected_frames.size();
    end

endmodule

@@ dv/ascii_can_frame_parser_dedup_top_tb.sv @@
module ascii_can_frame_parser_dedup_top_tb;
    import ascp_pkg::*;

    localparam int LineChars  = 14;
    localparam int CharTarget = 1700;
    localparam int HoldCycles = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_rx_byte;
    logic        i_line_start;
    logic        o_valid;
    logic        i_stall;
    logic [11:0] o_frame_id;
    logic        o_remote_request;
    logic [3:0]  o_data_length;
    logic [7:0]  o_data_byte0;
    logic [7:0]  o_data_byte1;
    logic [7:0]  o_data_byte2;
    logic [7:0]  o_data_byte3;
    logic [7:0]  o_data_byte4;
    logic [7:0]  o_data_byte5;
    logic [7:0]  o_data_byte6;
    logic [7:0]  o_data_byte7;
    logic        o_format_error;

    t_frame      frame_seen;
    int          fail_count;
    int          pending;
    int          chars_sent;
    logic        quiet;
    logic        hold_request;
    logic        hold_served;
    int          stall_left;
    logic [7:0]  line_buf [LineChars];

    ascii_can_frame_parser_dedup_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .i_line_start     (i_line_start),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_id       (o_frame_id),
        .o_remote_request (o_remote_request),
        .o_data_length    (o_data_length),
        .o_data_byte0     (o_data_byte0),
        .o_data_byte1     (o_data_byte1),
        .o_data_byte2     (o_data_byte2),
        .o_data_byte3     (o_data_byte3),
        .o_data_byte4     (o_data_byte4),
        .o_data_byte5     (o_data_byte5),
        .o_data_byte6     (o_data_byte6),
        .o_data_byte7     (o_data_byte7),
        .o_format_error   (o_format_error)
    );

    assign frame_seen = {o_frame_id, o_remote_request, o_data_length,
                         o_data_byte7, o_data_byte6, o_data_byte5, o_data_byte4,
                         o_data_byte3, o_data_byte2, o_data_byte1, o_data_byte0,
                         o_format_error};

    can_frame_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char_valid  (i_valid),
        .i_char_stall  (o_stall),
        .i_rx_byte     (i_rx_byte),
        .i_line_start  (i_line_start),
        .i_frame_valid (o_valid),
        .i_frame_stall (i_stall),
        .i_frame       (frame_seen),
        .o_mismatches  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? CharZero + 8'(n) : CharUpA + 8'(n) - HexLetterBase;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic start);
        int idle;
        @(negedge i_clk);
        i_valid      = 1'b1;
        i_rx_byte    = c;
        i_line_start = start;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        chars_sent++;
        idle = quiet ? 0 : random_gap();
        if (idle > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (idle - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_line(input int count, input logic start);
        for (int i = 0; i < count; i++) begin
            send_char(line_buf[i], start && (i == 0));
        end
    endtask

    task automatic make_line();
        logic zero_id;
        zero_id = ($urandom_range(0, 19) == 0);
        for (int i = 0; i < 3; i++) begin
            line_buf[i] = zero_id ? CharZero : hex_char(4'($urandom_range(0, 15)));
        end
        line_buf[3] = $urandom_range(0, 1) ? CharOne : CharZero;
        line_buf[4] = CharZero + 8'($urandom_range(0, 8));
        for (int i = 5; i < LineChars - 1; i++) begin
            line_buf[i] = 8'($urandom_range(0, 255));
        end
        line_buf[LineChars - 1] = $urandom_range(0, 3) ? 8'h0D : 8'($urandom_range(0, 255));
    endtask

    // The receiver stalls at random and, once, holds off for a long stretch
    // while characters keep coming so that the block backs up.
    initial begin
        i_stall     = 1'b0;
        stall_left  = 0;
        hold_served = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_served) begin
                i_stall = 1'b1;
                repeat (HoldCycles) @(negedge i_clk);
                hold_served = 1'b1;
                i_stall     = 1'b0;
            end else if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else begin
                i_stall = 1'b0;
                if (!quiet) begin
                    stall_left = random_gap();
                end
            end
        end
    end

    initial begin
        int   kind;
        int   idx;
        int   waited;
        logic need_start;
        logic hold_done;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_rx_byte    = 8'h00;
        i_line_start = 1'b0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        chars_sent   = 0;
        need_start   = 1'b1;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Largest identifier, remote frame, length digit above eight, all-ones data.
        line_buf[0] = CharUpF;
        line_buf[1] = CharUpF;
        line_buf[2] = CharUpF;
        line_buf[3] = CharOne;
        line_buf[4] = CharNine;
        for (int i = 5; i < LineChars; i++) begin
            line_buf[i] = 8'hFF;
        end
        send_line(LineChars, 1'b1);

        // A partial line cut short by a new line start, then a line with
        // skipped identifier characters, a bad RTR digit and zero length.
        for (int i = 0; i < 5; i++) begin
            line_buf[i] = CharZero;
        end
        send_line(5, 1'b0);
        line_buf[0] = 8'h61;
        line_buf[1] = 8'h47;
        line_buf[2] = CharOne;
        line_buf[3] = 8'h58;
        line_buf[4] = CharZero;
        for (int i = 5; i < LineChars; i++) begin
            line_buf[i] = 8'h00;
        end
        send_line(LineChars, 1'b1);
        need_start = 1'b0;

        while (chars_sent < CharTarget) begin
            if ($urandom_range(0, 39) == 0) begin
                quiet = ~quiet;
            end
            if (!hold_done && chars_sent > 700) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                make_line();
                send_line(LineChars, need_start || ($urandom_range(0, 4) != 0));
                need_start = 1'b0;
            end else if (kind < 70) begin
                // Resend the previous line, sometimes with one data byte altered.
                if ($urandom_range(0, 1)) begin
                    idx = $urandom_range(5, LineChars - 2);
                    line_buf[idx] = 8'($urandom_range(0, 255));
                end
                send_line(LineChars, need_start || $urandom_range(0, 1));
                need_start = 1'b0;
            end else if (kind < 85) begin
                make_line();
                if ($urandom_range(0, 1)) begin
                    idx = $urandom_range(0, 2);
                    line_buf[idx] = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(8'h61, 8'h66));
                end
                if ($urandom_range(0, 1)) begin
                    line_buf[3] = 8'($urandom_range(0, 255));
                end
                if ($urandom_range(0, 1)) begin
                    line_buf[4] = 8'($urandom_range(0, 255));
                end
                send_line(LineChars, 1'b1);
                need_start = 1'b0;
            end else if (kind < 95) begin
                make_line();
                send_line($urandom_range(1, LineChars - 1), 1'($urandom_range(0, 1)));
                need_start = 1'b1;
            end else begin
                repeat ($urandom_range(1, 20)) begin
                    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
                end
                need_start = 1'b1;
            end
        end

        @(negedge i_clk);
        i_valid      = 1'b0;
        i_line_start = 1'b0;
        waited       = 0;
        while (pending != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
